// ===== sv/sqb_pkg.sv =====
// ----------------------------------------------------------------------------
// sqb_pkg: shared types and constants for the sprite quad batcher
// Item and command structs, state encodings, angle and CORDIC constants.
// ----------------------------------------------------------------------------
package sqb_pkg;

    // input operation codes
    typedef enum logic [1:0] {
        OP_COLOR    = 2'd0,
        OP_TEXTURED = 2'd1,
        OP_BEGIN    = 2'd2,
        OP_END      = 2'd3
    } op_t;

    // result kinds (also used for queue commands: vertex kind means a quad)
    typedef enum logic [1:0] {
        KIND_VERTEX = 2'd0,
        KIND_BIND   = 2'd1,
        KIND_DRAW   = 2'd2
    } kind_t;

    // configuration register indexes (paddr[2])
    localparam logic REG_IDX_LIMIT = 1'b0;
    localparam logic REG_IDX_WHITE = 1'b1;

    localparam logic [15:0] LIMIT_RESET = 16'd16384;
    localparam logic [31:0] WHITE_RESET = 32'd0;
    localparam logic [31:0] ONE_Q16     = 32'h0001_0000;
    localparam logic [31:0] WHITE_COLOR = 32'hFFFF_FFFF;

    // angle constants, Q16.16 degrees
    localparam logic signed [33:0] DEG360      = 34'sd23592960;
    localparam logic signed [33:0] DEG180      = 34'sd11796480;
    localparam logic signed [33:0] DEG90       = 34'sd5898240;
    // 92 turns: lifts any negative 32-bit angle to a positive one
    localparam logic signed [33:0] REDUCE_BIAS = 34'sd2170552320;
    localparam logic [2:0]         REDUCE_TOP  = 3'd7;

    // CORDIC: gain-corrected start value, Q2.30
    localparam logic signed [33:0] CORDIC_X0   = 34'sd652032874;
    localparam logic [3:0]         CORDIC_LAST = 4'd15;

    // rounding offset for the >>47 vertex scaling
    localparam logic signed [65:0] ROUND_BIAS  = 66'sd70368744177664;

    localparam int FIFO_DEPTH = 2;

    typedef struct packed {
        op_t                operation;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rotation_deg;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [31:0]        color_rgba;
        logic signed [31:0] tiling_factor;
        logic [31:0]        texture_id;
    } in_item_t;

    // command passed from front to back
    typedef struct packed {
        kind_t              kind;
        logic               last;
        logic [4:0]         slot_index;
        logic [31:0]        bound_texture;
        logic [18:0]        index_count;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] rotation_deg;
        logic signed [31:0] size_x;
        logic signed [31:0] size_y;
        logic [31:0]        vertex_color;
        logic signed [31:0] vertex_tiling;
    } cmd_t;

    typedef struct packed {
        kind_t              kind;
        logic signed [31:0] vert_x;
        logic signed [31:0] vert_y;
        logic signed [31:0] vert_z;
        logic               tex_u;
        logic               tex_v;
        logic [31:0]        vertex_color;
        logic [4:0]         slot_index;
        logic signed [31:0] vertex_tiling;
        logic [31:0]        bound_texture;
        logic [18:0]        index_count;
        logic               last;
    } res_t;

    typedef struct packed {
        logic [5:0]  slots_used;
        logic [15:0] quads_in_batch;
    } fe_status_t;

    typedef enum logic [2:0] {
        F_IDLE,
        F_BIND_RD,
        F_BIND_PUSH,
        F_DRAW,
        F_LOOK,
        F_ALLOC,
        F_QUAD
    } front_state_t;

    // what follows a flush
    typedef enum logic [1:0] {
        POST_DONE,
        POST_QUAD,
        POST_ALLOC
    } post_t;

    typedef enum logic [2:0] {
        B_IDLE,
        B_REDUCE,
        B_FOLD,
        B_CORDIC,
        B_SIGN,
        B_MUL,
        B_SUM,
        B_OUT
    } back_state_t;

    // arctan(2^-i) in Q16.16 degrees
    function automatic logic signed [33:0] atan_deg(input logic [3:0] i);
        logic signed [33:0] v;
        case (i)
            4'd0:    v = 34'sd2949120;
            4'd1:    v = 34'sd1740967;
            4'd2:    v = 34'sd919879;
            4'd3:    v = 34'sd466945;
            4'd4:    v = 34'sd234379;
            4'd5:    v = 34'sd117304;
            4'd6:    v = 34'sd58666;
            4'd7:    v = 34'sd29335;
            4'd8:    v = 34'sd14668;
            4'd9:    v = 34'sd7334;
            4'd10:   v = 34'sd3667;
            4'd11:   v = 34'sd1833;
            4'd12:   v = 34'sd917;
            4'd13:   v = 34'sd458;
            4'd14:   v = 34'sd229;
            4'd15:   v = 34'sd115;
            default: v = 34'sd0;
        endcase
        return v;
    endfunction

    // corner texture coordinates: (0,0) (1,0) (1,1) (0,1)
    function automatic logic corner_u(input logic [1:0] k);
        return k[0] ^ k[1];
    endfunction

    function automatic logic corner_v(input logic [1:0] k);
        return k[1];
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [33:0] v);
        logic signed [31:0] r;
        if (v > 34'sd2147483647) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -34'sd2147483648) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// ===== sv/sprite_quad_batcher.sv =====
// ----------------------------------------------------------------------------
// sprite_quad_batcher: batched sprite quad vertex setup
// Quad: front intake, then the serial back end (pop, angle reduction, fold,
//   CORDIC, sign, 4 shared-multiplier products, sum and output per vertex);
//   the back end takes no new quad until all four corners of the last are out.
// Texture lookup reads the used slots in turn; a flush binds each used slot.
// Reset (aresetn low, synchronous) empties the batch and queue, restores the
//   registers; no clearing pass is needed.
// ----------------------------------------------------------------------------
module sprite_quad_batcher #(
    parameter int TEXTURE_SLOTS = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    // request stream
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, rotation_deg, size_x, size_y, color_rgba,
    // tiling_factor, texture_id
    input  logic [287:0] s_tdata,
    // operation
    input  logic [1:0]   s_tuser,
    // result stream
    output logic         m_tvalid,
    input  logic         m_tready,
    // vert_x, vert_y, vert_z, tex_u, tex_v, vertex_color, slot_index,
    // vertex_tiling, bound_texture, index_count, 6 zero bits
    output logic [223:0] m_tdata,
    // kind
    output logic [1:0]   m_tuser,
    output logic         m_tlast,
    // configuration
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);
    logic [15:0]         limit_reg;
    logic [31:0]         white_reg;
    logic                cfg_write;

    sqb_pkg::in_item_t   s_item;
    sqb_pkg::cmd_t       q_data, q_head;
    logic                q_push, q_pop, q_full, q_empty;
    sqb_pkg::res_t       res;
    sqb_pkg::fe_status_t fe_status;

    // configuration registers
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == sqb_pkg::REG_IDX_WHITE) ? white_reg
                                                            : {16'b0, limit_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= sqb_pkg::LIMIT_RESET;
            white_reg <= sqb_pkg::WHITE_RESET;
        end else if (cfg_write) begin
            if (paddr[2] == sqb_pkg::REG_IDX_LIMIT) begin
                limit_reg <= pwdata[15:0];
            end else begin
                white_reg <= pwdata;
            end
        end
    end

    // request unpacking
    always_comb begin
        s_item.operation     = sqb_pkg::op_t'(s_tuser);
        s_item.pos_x         = s_tdata[31:0];
        s_item.pos_y         = s_tdata[63:32];
        s_item.pos_z         = s_tdata[95:64];
        s_item.rotation_deg  = s_tdata[127:96];
        s_item.size_x        = s_tdata[159:128];
        s_item.size_y        = s_tdata[191:160];
        s_item.color_rgba    = s_tdata[223:192];
        s_item.tiling_factor = s_tdata[255:224];
        s_item.texture_id    = s_tdata[287:256];
    end

    sqb_front #(
        .TEXTURE_SLOTS(TEXTURE_SLOTS)
    ) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_tvalid),
        .s_ready          (s_tready),
        .s_item           (s_item),
        .batch_quad_limit (limit_reg),
        .white_texture_id (white_reg),
        .q_full           (q_full),
        .q_push           (q_push),
        .q_data           (q_data),
        .status           (fe_status)
    );

    sqb_cmd_fifo u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sqb_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_empty (q_empty),
        .q_head  (q_head),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // result packing
    assign m_tuser = res.kind;
    assign m_tlast = res.last;
    assign m_tdata = {6'b0, res.index_count, res.bound_texture, res.vertex_tiling,
                      res.slot_index, res.vertex_color, res.tex_v, res.tex_u,
                      res.vert_z, res.vert_y, res.vert_x};

    // checks
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_push && q_full)) else $error("command pushed into full queue");

    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !(q_pop && q_empty)) else $error("command popped from empty queue");

    a_slots_range: assert property (@(posedge aclk) disable iff (!aresetn)
        fe_status.slots_used >= 6'd1 && fe_status.slots_used <= 6'(TEXTURE_SLOTS))
        else $error("slot count out of range");

    a_bind_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && res.kind == sqb_pkg::KIND_BIND) |->
        (res.slot_index < 5'(TEXTURE_SLOTS - 1) || res.slot_index == 5'(TEXTURE_SLOTS - 1)))
        else $error("bind result names a slot beyond the table");

endmodule

// ===== sv/sqb_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sqb_cmd_fifo: command queue between front and back
// Small register FIFO; head is shown combinationally from storage.
// ----------------------------------------------------------------------------
module sqb_cmd_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  sqb_pkg::cmd_t push_data,
    output logic          full,
    input  logic          pop,
    output sqb_pkg::cmd_t head,
    output logic          empty
);
    localparam int DEPTH = sqb_pkg::FIFO_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);

    sqb_pkg::cmd_t   entry_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // pointer and fill bookkeeping
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== sv/sqb_front.sv =====
// ----------------------------------------------------------------------------
// sqb_front: request intake, batch bookkeeping and texture slot table
// Classifies each request, runs slot lookup and flush sequencing, and
// queues bind, draw and quad commands for the back end.
// ----------------------------------------------------------------------------
module sqb_front #(
    parameter int TEXTURE_SLOTS = 32
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  sqb_pkg::in_item_t     s_item,
    input  logic [15:0]           batch_quad_limit,
    input  logic [31:0]           white_texture_id,
    input  logic                  q_full,
    output logic                  q_push,
    output sqb_pkg::cmd_t         q_data,
    output sqb_pkg::fe_status_t   status
);
    localparam int AW = $clog2(TEXTURE_SLOTS);
    localparam int CW = $clog2(TEXTURE_SLOTS + 1);
    localparam logic [CW-1:0] SLOTS_C = CW'(TEXTURE_SLOTS);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    sqb_pkg::front_state_t state_reg, state_next;
    sqb_pkg::post_t        post_reg, post_next;
    sqb_pkg::in_item_t     item_reg, item_next;
    logic [CW-1:0]         used_reg, used_next;
    logic [15:0]           quads_reg, quads_next;
    logic [CW-1:0]         scan_idx_reg, scan_idx_next;
    logic                  cmp_valid_reg, cmp_valid_next;
    logic [AW-1:0]         cmp_idx_reg, cmp_idx_next;
    logic [CW-1:0]         bind_idx_reg, bind_idx_next;
    logic [AW-1:0]         slot_reg, slot_next;

    // slot table memory
    logic [31:0]           slot_mem [TEXTURE_SLOTS];
    logic [31:0]           rdata_reg;
    logic [AW-1:0]         raddr;
    logic                  mem_we;
    logic [18:0]           draw_count;
    logic                  textured;

    assign status.slots_used     = 6'(used_reg);
    assign status.quads_in_batch = quads_reg;

    assign draw_count = ({3'b0, quads_reg} << 2) + ({3'b0, quads_reg} << 1);
    assign textured   = (item_reg.operation == sqb_pkg::OP_TEXTURED);
    assign raddr      = (state_reg == sqb_pkg::F_LOOK) ? scan_idx_reg[AW-1:0]
                                                       : bind_idx_reg[AW-1:0];

    // sequencer
    always_comb begin
        state_next     = state_reg;
        post_next      = post_reg;
        item_next      = item_reg;
        used_next      = used_reg;
        quads_next     = quads_reg;
        scan_idx_next  = scan_idx_reg;
        cmp_valid_next = cmp_valid_reg;
        cmp_idx_next   = cmp_idx_reg;
        bind_idx_next  = bind_idx_reg;
        slot_next      = slot_reg;
        s_ready        = 1'b0;
        q_push         = 1'b0;
        q_data         = '0;
        mem_we         = 1'b0;

        case (state_reg)
            sqb_pkg::F_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    item_next = s_item;
                    case (s_item.operation)
                        sqb_pkg::OP_BEGIN: begin
                            quads_next = '0;
                            used_next  = ONE_C;
                        end
                        sqb_pkg::OP_END: begin
                            bind_idx_next = '0;
                            post_next     = sqb_pkg::POST_DONE;
                            state_next    = sqb_pkg::F_BIND_RD;
                        end
                        default: begin
                            if (quads_reg >= batch_quad_limit) begin
                                // budget full: flush first
                                bind_idx_next = '0;
                                post_next     = sqb_pkg::POST_QUAD;
                                state_next    = sqb_pkg::F_BIND_RD;
                            end else if (s_item.operation == sqb_pkg::OP_COLOR) begin
                                slot_next  = '0;
                                state_next = sqb_pkg::F_QUAD;
                            end else begin
                                scan_idx_next  = ONE_C;
                                cmp_valid_next = 1'b0;
                                state_next     = sqb_pkg::F_LOOK;
                            end
                        end
                    endcase
                end
            end

            // registered table read of this slot
            sqb_pkg::F_BIND_RD: begin
                state_next = sqb_pkg::F_BIND_PUSH;
            end

            sqb_pkg::F_BIND_PUSH: begin
                if (!q_full) begin
                    q_push             = 1'b1;
                    q_data.kind        = sqb_pkg::KIND_BIND;
                    q_data.slot_index  = 5'(bind_idx_reg);
                    q_data.bound_texture = (bind_idx_reg == '0) ? white_texture_id
                                                                : rdata_reg;
                    bind_idx_next      = bind_idx_reg + 1'b1;
                    state_next = (bind_idx_reg + 1'b1 < used_reg) ? sqb_pkg::F_BIND_RD
                                                                  : sqb_pkg::F_DRAW;
                end
            end

            sqb_pkg::F_DRAW: begin
                if (!q_full) begin
                    q_push             = 1'b1;
                    q_data.kind        = sqb_pkg::KIND_DRAW;
                    q_data.index_count = draw_count;
                    q_data.last        = (post_reg == sqb_pkg::POST_DONE);
                    case (post_reg)
                        sqb_pkg::POST_QUAD: begin
                            quads_next = '0;
                            used_next  = ONE_C;
                            if (item_reg.operation == sqb_pkg::OP_COLOR) begin
                                slot_next  = '0;
                                state_next = sqb_pkg::F_QUAD;
                            end else begin
                                scan_idx_next  = ONE_C;
                                cmp_valid_next = 1'b0;
                                state_next     = sqb_pkg::F_LOOK;
                            end
                        end
                        sqb_pkg::POST_ALLOC: begin
                            quads_next = '0;
                            used_next  = ONE_C;
                            state_next = sqb_pkg::F_ALLOC;
                        end
                        default: begin
                            state_next = sqb_pkg::F_IDLE;
                        end
                    endcase
                end
            end

            // pipelined scan: read one slot, compare the previous read
            sqb_pkg::F_LOOK: begin
                if (cmp_valid_reg && rdata_reg == item_reg.texture_id) begin
                    slot_next  = cmp_idx_reg;
                    state_next = sqb_pkg::F_QUAD;
                end else if (scan_idx_reg < used_reg) begin
                    cmp_valid_next = 1'b1;
                    cmp_idx_next   = scan_idx_reg[AW-1:0];
                    scan_idx_next  = scan_idx_reg + 1'b1;
                end else if (used_reg >= SLOTS_C) begin
                    // table full: flush, then allocate in the fresh table
                    bind_idx_next = '0;
                    post_next     = sqb_pkg::POST_ALLOC;
                    state_next    = sqb_pkg::F_BIND_RD;
                end else begin
                    state_next = sqb_pkg::F_ALLOC;
                end
            end

            sqb_pkg::F_ALLOC: begin
                mem_we     = 1'b1;
                slot_next  = used_reg[AW-1:0];
                used_next  = used_reg + 1'b1;
                state_next = sqb_pkg::F_QUAD;
            end

            sqb_pkg::F_QUAD: begin
                if (!q_full) begin
                    q_push              = 1'b1;
                    q_data.kind         = sqb_pkg::KIND_VERTEX;
                    q_data.slot_index   = 5'(slot_reg);
                    q_data.pos_x        = item_reg.pos_x;
                    q_data.pos_y        = item_reg.pos_y;
                    q_data.pos_z        = item_reg.pos_z;
                    q_data.rotation_deg = item_reg.rotation_deg;
                    q_data.size_x       = item_reg.size_x;
                    q_data.size_y       = item_reg.size_y;
                    q_data.vertex_color = textured ? sqb_pkg::WHITE_COLOR
                                                   : item_reg.color_rgba;
                    q_data.vertex_tiling = textured ? item_reg.tiling_factor
                                                    : sqb_pkg::ONE_Q16;
                    quads_next = quads_reg + 1'b1;
                    state_next = sqb_pkg::F_IDLE;
                end
            end

            default: begin
                state_next = sqb_pkg::F_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sqb_pkg::F_IDLE;
            post_reg      <= sqb_pkg::POST_DONE;
            used_reg      <= ONE_C;
            quads_reg     <= '0;
            scan_idx_reg  <= '0;
            cmp_valid_reg <= 1'b0;
            bind_idx_reg  <= '0;
        end else begin
            state_reg     <= state_next;
            post_reg      <= post_next;
            used_reg      <= used_next;
            quads_reg     <= quads_next;
            scan_idx_reg  <= scan_idx_next;
            cmp_valid_reg <= cmp_valid_next;
            bind_idx_reg  <= bind_idx_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
    end

    // slot table: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            slot_mem[used_reg[AW-1:0]] <= item_reg.texture_id;
        end
        rdata_reg <= slot_mem[raddr];
    end

endmodule

// ===== sv/sqb_back.sv =====
// ----------------------------------------------------------------------------
// sqb_back: vertex generation and result output register
// Reduces the angle, runs a serial CORDIC, forms the four size products
// on one shared multiplier and emits the four corners; bind and draw pass through.
// ----------------------------------------------------------------------------
module sqb_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          q_empty,
    input  sqb_pkg::cmd_t q_head,
    output logic          q_pop,
    output logic          m_valid,
    input  logic          m_ready,
    output sqb_pkg::res_t m_res
);
    sqb_pkg::back_state_t state_reg, state_next;
    sqb_pkg::cmd_t        quad_reg, quad_next;
    logic signed [33:0]   ang_reg, ang_next;
    logic [2:0]           red_k_reg, red_k_next;
    logic                 neg_reg, neg_next;
    logic signed [33:0]   x_reg, x_next;
    logic signed [33:0]   y_reg, y_next;
    logic [3:0]           it_reg, it_next;
    logic signed [31:0]   c_reg, c_next;
    logic signed [31:0]   s_reg, s_next;
    logic [1:0]           mul_idx_reg, mul_idx_next;
    logic signed [63:0]   prod_reg [4];
    logic [1:0]           corner_reg, corner_next;
    logic signed [19:0]   rx_reg, rx_next;
    logic signed [19:0]   ry_reg, ry_next;
    logic                 out_valid_reg;
    sqb_pkg::res_t        out_reg, out_next;
    logic                 out_load;
    logic                 out_free;

    logic signed [33:0]   red_step;
    logic signed [33:0]   fold_a;
    logic signed [33:0]   x_sh, y_sh;
    logic signed [33:0]   cos_full, sin_full;
    logic signed [31:0]   mul_a, mul_b;
    logic signed [63:0]   mul_p;
    logic                 cu, cv;
    logic signed [65:0]   p0, p1, p2, p3;
    logic signed [65:0]   sum_x, sum_y, shx, shy;
    logic signed [33:0]   head_ang;

    assign m_valid  = out_valid_reg;
    assign m_res    = out_reg;
    assign out_free = !out_valid_reg || m_ready;

    assign head_ang = {{2{q_head.rotation_deg[31]}}, q_head.rotation_deg};
    assign red_step = sqb_pkg::DEG360 <<< red_k_reg;
    assign x_sh     = x_reg >>> it_reg;
    assign y_sh     = y_reg >>> it_reg;
    assign cos_full = neg_reg ? -x_reg : x_reg;
    assign sin_full = neg_reg ? -y_reg : y_reg;

    // fold [0,360) to [-90,90] with a sign flip
    always_comb begin
        fold_a   = (ang_reg > sqb_pkg::DEG180) ? ang_reg - sqb_pkg::DEG360 : ang_reg;
        neg_next = 1'b0;
        if (fold_a > sqb_pkg::DEG90) begin
            fold_a   = fold_a - sqb_pkg::DEG180;
            neg_next = 1'b1;
        end else if (fold_a < -sqb_pkg::DEG90) begin
            fold_a   = fold_a + sqb_pkg::DEG180;
            neg_next = 1'b1;
        end
    end

    // shared multiplier: cos*sx, sin*sy, sin*sx, cos*sy
    assign mul_a = (mul_idx_reg == 2'd0 || mul_idx_reg == 2'd3) ? c_reg : s_reg;
    assign mul_b = (mul_idx_reg == 2'd0 || mul_idx_reg == 2'd2) ? quad_reg.size_x
                                                                : quad_reg.size_y;
    assign mul_p = mul_a * mul_b;

    // corner sums with round-to-nearest and >>47
    assign cu    = sqb_pkg::corner_u(corner_reg);
    assign cv    = sqb_pkg::corner_v(corner_reg);
    assign p0    = {{2{prod_reg[0][63]}}, prod_reg[0]};
    assign p1    = {{2{prod_reg[1][63]}}, prod_reg[1]};
    assign p2    = {{2{prod_reg[2][63]}}, prod_reg[2]};
    assign p3    = {{2{prod_reg[3][63]}}, prod_reg[3]};
    assign sum_x = (cu ? p0 : -p0) - (cv ? p1 : -p1) + sqb_pkg::ROUND_BIAS;
    assign sum_y = (cu ? p2 : -p2) + (cv ? p3 : -p3) + sqb_pkg::ROUND_BIAS;
    assign shx   = sum_x >>> 47;
    assign shy   = sum_y >>> 47;

    // sequencer
    always_comb begin
        state_next   = state_reg;
        quad_next    = quad_reg;
        ang_next     = ang_reg;
        red_k_next   = red_k_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        it_next      = it_reg;
        c_next       = c_reg;
        s_next       = s_reg;
        mul_idx_next = mul_idx_reg;
        corner_next  = corner_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        q_pop        = 1'b0;
        out_load     = 1'b0;
        out_next     = '0;

        case (state_reg)
            sqb_pkg::B_IDLE: begin
                if (!q_empty) begin
                    if (q_head.kind == sqb_pkg::KIND_VERTEX) begin
                        q_pop      = 1'b1;
                        quad_next  = q_head;
                        ang_next   = q_head.rotation_deg[31] ?
                                     head_ang + sqb_pkg::REDUCE_BIAS : head_ang;
                        red_k_next = sqb_pkg::REDUCE_TOP;
                        state_next = sqb_pkg::B_REDUCE;
                    end else if (out_free) begin
                        // bind and draw go straight to the output register
                        q_pop                  = 1'b1;
                        out_load               = 1'b1;
                        out_next.kind          = q_head.kind;
                        out_next.slot_index    = q_head.slot_index;
                        out_next.bound_texture = q_head.bound_texture;
                        out_next.index_count   = q_head.index_count;
                        out_next.last          = q_head.last;
                    end
                end
            end

            // modulo 360 by subtracting 360<<k, k from top down
            sqb_pkg::B_REDUCE: begin
                if (ang_reg >= red_step) begin
                    ang_next = ang_reg - red_step;
                end
                red_k_next = red_k_reg - 1'b1;
                if (red_k_reg == '0) begin
                    state_next = sqb_pkg::B_FOLD;
                end
            end

            sqb_pkg::B_FOLD: begin
                ang_next   = fold_a;
                x_next     = sqb_pkg::CORDIC_X0;
                y_next     = '0;
                it_next    = '0;
                state_next = sqb_pkg::B_CORDIC;
            end

            // one rotation step per cycle
            sqb_pkg::B_CORDIC: begin
                if (ang_reg >= 0) begin
                    x_next   = x_reg - y_sh;
                    y_next   = y_reg + x_sh;
                    ang_next = ang_reg - sqb_pkg::atan_deg(it_reg);
                end else begin
                    x_next   = x_reg + y_sh;
                    y_next   = y_reg - x_sh;
                    ang_next = ang_reg + sqb_pkg::atan_deg(it_reg);
                end
                it_next = it_reg + 1'b1;
                if (it_reg == sqb_pkg::CORDIC_LAST) begin
                    state_next = sqb_pkg::B_SIGN;
                end
            end

            sqb_pkg::B_SIGN: begin
                c_next       = cos_full[31:0];
                s_next       = sin_full[31:0];
                mul_idx_next = '0;
                state_next   = sqb_pkg::B_MUL;
            end

            sqb_pkg::B_MUL: begin
                mul_idx_next = mul_idx_reg + 1'b1;
                if (mul_idx_reg == 2'd3) begin
                    corner_next = '0;
                    state_next  = sqb_pkg::B_SUM;
                end
            end

            sqb_pkg::B_SUM: begin
                rx_next    = shx[19:0];
                ry_next    = shy[19:0];
                state_next = sqb_pkg::B_OUT;
            end

            sqb_pkg::B_OUT: begin
                if (out_free) begin
                    out_load               = 1'b1;
                    out_next.kind          = sqb_pkg::KIND_VERTEX;
                    out_next.vert_x        = sqb_pkg::sat32(
                        {{2{quad_reg.pos_x[31]}}, quad_reg.pos_x} +
                        {{14{rx_reg[19]}}, rx_reg});
                    out_next.vert_y        = sqb_pkg::sat32(
                        {{2{quad_reg.pos_y[31]}}, quad_reg.pos_y} +
                        {{14{ry_reg[19]}}, ry_reg});
                    out_next.vert_z        = quad_reg.pos_z;
                    out_next.tex_u         = cu;
                    out_next.tex_v         = cv;
                    out_next.vertex_color  = quad_reg.vertex_color;
                    out_next.slot_index    = quad_reg.slot_index;
                    out_next.vertex_tiling = quad_reg.vertex_tiling;
                    out_next.last          = (corner_reg == 2'd3);
                    corner_next            = corner_reg + 1'b1;
                    state_next = (corner_reg == 2'd3) ? sqb_pkg::B_IDLE : sqb_pkg::B_SUM;
                end
            end

            default: begin
                state_next = sqb_pkg::B_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= sqb_pkg::B_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        quad_reg    <= quad_next;
        ang_reg     <= ang_next;
        red_k_reg   <= red_k_next;
        x_reg       <= x_next;
        y_reg       <= y_next;
        it_reg      <= it_next;
        c_reg       <= c_next;
        s_reg       <= s_next;
        mul_idx_reg <= mul_idx_next;
        corner_reg  <= corner_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        if (state_reg == sqb_pkg::B_FOLD) begin
            neg_reg <= neg_next;
        end
        if (state_reg == sqb_pkg::B_MUL) begin
            prod_reg[mul_idx_reg] <= mul_p;
        end
        if (out_load) begin
            out_reg <= out_next;
        end
    end

endmodule
